// ===== hdl/omx_pkg.sv =====
package omx_pkg;

	localparam int WORD_BITS   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IFRAC       = 32;
	localparam int MAG_W       = 63;
	localparam int SPLIT_W     = 38;
	localparam int Q_W         = 6;
	localparam int SPLIT_CELLS = 6;
	localparam int EXP_TERMS   = 12;
	localparam int DIV_CELLS   = 32;
	localparam int LANE_LAT    = DIV_CELLS + 5;
	localparam int PROD_W      = 96;

	localparam logic [SPLIT_W-1:0] LN2_Q   = 38'd2977044472;
	localparam logic [MAG_W-1:0]   MAG_MAX = '1;
	localparam logic [63:0]        ONE_Q   = 64'd1 << IFRAC;
	localparam logic [63:0]        U_OVER  = 64'd21 << IFRAC;
	localparam logic [63:0]        U_UNDER = 64'd32 << IFRAC;

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	localparam logic [1:0] REG_EXP_SCALE   = 2'd0;
	localparam logic [1:0] REG_GAIN        = 2'd1;
	localparam logic [1:0] REG_DIVIDE_MODE = 2'd2;

	localparam logic [31:0] EXP_SCALE_RST   = 32'd65536;
	localparam logic [31:0] GAIN_RST        = 32'd65536;
	localparam logic        DIVIDE_MODE_RST = 1'b1;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic                 sat;
		logic                 dz;
	} tag_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] y;
		logic [WORD_BITS-1:0] e;
		logic                 uneg;
		logic                 over;
		logic                 under;
		logic [SPLIT_W-1:0]   mag;
		logic [Q_W-1:0]       q;
		logic [31:0]          r;
		logic [32:0]          term;
		logic [33:0]          sum;
	} ex_t;

	typedef struct packed {
		logic [31:0]          vm;
		logic [MAG_W-1:0]     fmag;
		logic                 vneg;
		logic                 rneg;
		logic                 ovf;
		logic [MAG_W-1:0]     rem;
		logic [31:0]          low;
		tag_t                 tag;
	} ln_t;

endpackage

// ===== hdl/one_minus_exp_correction_core.sv =====
// channel   | ports                                         | beat taken when
// ----------+-----------------------------------------------+-----------------------
// point in  | start, busy, x_value, y_value, e_value        | start high, busy low
// result    | done, y_corrected, e_corrected, status        | done high, one cycle
// config    | cfg_we, cfg_index, cfg_data                   | cfg_we high
//
// one point enters per cycle; busy stays low
// each result passes through 6 ln2 split cells, 12 taylor cells
// of 3 stages, the factor multiply, then 32 divider cells and the scale multiply per lane
// reset clears the config registers to their defaults and empties the pipe
// results cannot be held off; done marks each beat for exactly one cycle
module one_minus_exp_correction_core import omx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] x_value,
	input  logic [WORD_BITS-1:0] y_value,
	input  logic [WORD_BITS-1:0] e_value,
	output logic                 done,
	output logic [WORD_BITS-1:0] y_corrected,
	output logic [WORD_BITS-1:0] e_corrected,
	output logic [1:0]           status,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int             LAT     = 3 + SPLIT_CELLS + 1 + 3*EXP_TERMS + 6 + LANE_LAT + 1;
	localparam logic [Q_W-1:0] Q_LIMIT = 6'd47;

	logic [31:0] exp_scale_q, gain_q;
	logic        divide_mode_q;

	logic acc;
	logic gneg;
	logic [31:0] gm;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic        xneg_s1;
	logic [31:0] xm_s1;
	logic [WORD_BITS-1:0] y_s1, e_s1, y_s2, e_s2, y_s5, e_s5, y_s6, e_s6;
	logic [WORD_BITS-1:0] y_s7, e_s7, y_s8, e_s8, y_s9, e_s9, y_s10, e_s10;
	logic        uneg_s2;
	logic [63:0] tm_s2;
	ex_t         ex_s3, ex_s4, ex_fix, ex_init;
	logic [63:0] exp_s5, exp_c, rnd;
	logic        over_s5;
	logic        wneg_s6, sat_s6, wneg_s7, sat_s7, wneg_s8, sat_s8, wneg_s9, sat_s9;
	logic [MAG_W-1:0] wmag_s6;
	logic [63:0] plo_s7, plo_s8;
	logic [30:0] whi_s7;
	logic [62:0] phi_s8;
	logic [PROD_W-1:0] tot_s9;
	logic [MAG_W-1:0] fmag_s10;
	logic        fneg_s10, sat_s10;
	logic        big;
	tag_t        tag_c;

	logic sv [0:SPLIT_CELLS];
	ex_t  sx [0:SPLIT_CELLS];
	logic tv [0:EXP_TERMS];
	ex_t  tx [0:EXP_TERMS];

	logic                 ly_v, ly_sat, ly_vneg, le_sat, le_vneg;
	logic [WORD_BITS-1:0] ly_word, le_word;
	tag_t                 ly_tag;

	logic [WORD_BITS-1:0] y_s11, e_s11;
	status_t              st_s11;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_scale_q   <= EXP_SCALE_RST;
			gain_q        <= GAIN_RST;
			divide_mode_q <= DIVIDE_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXP_SCALE:   exp_scale_q   <= cfg_data;
				REG_GAIN:        gain_q        <= cfg_data;
				REG_DIVIDE_MODE: divide_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign gneg = gain_q[31];
	assign gm   = gneg ? 32'(-gain_q) : gain_q;

	always_comb begin
		ex_init       = '0;
		ex_init.y     = y_s2;
		ex_init.e     = e_s2;
		ex_init.uneg  = uneg_s2;
		ex_init.over  = !uneg_s2 && tm_s2 >= U_OVER;
		ex_init.under = uneg_s2 && tm_s2 > U_UNDER;
		ex_init.mag   = ((!uneg_s2 && tm_s2 >= U_OVER) || (uneg_s2 && tm_s2 > U_UNDER)) ?
			'0 : tm_s2[SPLIT_W-1:0];
	end

	// split the argument into k*ln2 + r
	assign sv[0] = v_s3;
	assign sx[0] = ex_s3;

	for (genvar i = 0; i < SPLIT_CELLS; i++) begin : g_split
		omx_split_cell #(.SHIFT(SPLIT_CELLS-1-i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (sv[i]),
			.ex_in  (sx[i]),
			.v_s1   (sv[i+1]),
			.ex_s1  (sx[i+1])
		);
	end

	always_comb begin
		ex_fix      = sx[SPLIT_CELLS];
		ex_fix.term = 33'(ONE_Q);
		ex_fix.sum  = 34'(ONE_Q);
		if (ex_fix.uneg && ex_fix.mag != '0) begin
			ex_fix.q = sx[SPLIT_CELLS].q + 1'b1;
			ex_fix.r = 32'(LN2_Q - sx[SPLIT_CELLS].mag);
		end else begin
			ex_fix.r = sx[SPLIT_CELLS].mag[31:0];
		end
	end

	// taylor series of exp(r)
	assign tv[0] = v_s4;
	assign tx[0] = ex_s4;

	for (genvar i = 0; i < EXP_TERMS; i++) begin : g_taylor
		omx_taylor_cell #(.N(i+1)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (tv[i]),
			.ex_in  (tx[i]),
			.v_s3   (tv[i+1]),
			.ex_s3  (tx[i+1])
		);
	end

	assign rnd = (tx[EXP_TERMS].q == '0) ? 64'd0 : (64'd1 << (tx[EXP_TERMS].q - 1'b1));

	always_comb begin
		if (tx[EXP_TERMS].under) begin
			exp_c = '0;
		end else if (!tx[EXP_TERMS].uneg) begin
			exp_c = 64'(tx[EXP_TERMS].sum) << tx[EXP_TERMS].q;
		end else begin
			exp_c = (64'(tx[EXP_TERMS].sum) + rnd) >> tx[EXP_TERMS].q;
		end
	end

	assign big = |tot_s9[PROD_W-1:FRAC_BITS+MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s1  <= acc;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= sv[SPLIT_CELLS];
			v_s5  <= tv[EXP_TERMS];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= ly_v;
		end
	end

	always_ff @(posedge clk) begin
		xneg_s1 <= x_value[WORD_BITS-1];
		xm_s1   <= x_value[WORD_BITS-1] ? 32'(-x_value) : x_value;
		y_s1    <= y_value;
		e_s1    <= e_value;

		uneg_s2 <= !xneg_s1;
		tm_s2   <= 64'(exp_scale_q) * 64'(xm_s1);
		y_s2    <= y_s1;
		e_s2    <= e_s1;

		ex_s3 <= ex_init;

		ex_s4 <= ex_fix;

		exp_s5  <= exp_c;
		over_s5 <= tx[EXP_TERMS].over;
		y_s5    <= tx[EXP_TERMS].y;
		e_s5    <= tx[EXP_TERMS].e;

		if (over_s5) begin
			wneg_s6 <= 1'b1;
			wmag_s6 <= MAG_MAX;
		end else if (exp_s5 <= ONE_Q) begin
			wneg_s6 <= 1'b0;
			wmag_s6 <= MAG_W'(ONE_Q - exp_s5);
		end else begin
			wneg_s6 <= 1'b1;
			wmag_s6 <= MAG_W'(exp_s5 - ONE_Q);
		end
		sat_s6 <= over_s5;
		y_s6   <= y_s5;
		e_s6   <= e_s5;

		plo_s7  <= 64'(gm) * 64'(wmag_s6[31:0]);
		whi_s7  <= wmag_s6[62:32];
		wneg_s7 <= wneg_s6;
		sat_s7  <= sat_s6;
		y_s7    <= y_s6;
		e_s7    <= e_s6;

		plo_s8  <= plo_s7;
		phi_s8  <= 63'(gm) * 63'(whi_s7);
		wneg_s8 <= wneg_s7;
		sat_s8  <= sat_s7;
		y_s8    <= y_s7;
		e_s8    <= e_s7;

		tot_s9  <= PROD_W'(plo_s8) + (PROD_W'(phi_s8) << 32) +
			(PROD_W'(1) << (FRAC_BITS-1));
		wneg_s9 <= wneg_s8;
		sat_s9  <= sat_s8;
		y_s9    <= y_s8;
		e_s9    <= e_s8;

		fmag_s10 <= big ? MAG_MAX : tot_s9[FRAC_BITS+MAG_W-1:FRAC_BITS];
		sat_s10  <= sat_s9 || big;
		fneg_s10 <= gneg ^ wneg_s9;
		y_s10    <= y_s9;
		e_s10    <= e_s9;
	end

	assign tag_c.sat = sat_s10;
	assign tag_c.dz  = divide_mode_q && fmag_s10 == '0;

	omx_lane u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (v_s10),
		.raw     (y_s10),
		.fmag    (fmag_s10),
		.fneg    (fneg_s10),
		.dm      (divide_mode_q),
		.tag_in  (tag_c),
		.v_s5    (ly_v),
		.word_s5 (ly_word),
		.sat_s5  (ly_sat),
		.vneg_s5 (ly_vneg),
		.tag_s5  (ly_tag)
	);

	omx_lane u_lane_e (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (v_s10),
		.raw     (e_s10),
		.fmag    (fmag_s10),
		.fneg    (fneg_s10),
		.dm      (divide_mode_q),
		.tag_in  ('0),
		.v_s5    (),
		.word_s5 (le_word),
		.sat_s5  (le_sat),
		.vneg_s5 (le_vneg),
		.tag_s5  ()
	);

	always_ff @(posedge clk) begin
		if (ly_tag.dz) begin
			y_s11  <= ly_vneg ? WORD_MIN : WORD_MAX;
			e_s11  <= le_vneg ? WORD_MIN : WORD_MAX;
			st_s11 <= ST_DZ;
		end else begin
			y_s11  <= ly_word;
			e_s11  <= le_word;
			st_s11 <= (ly_tag.sat || ly_sat || le_sat) ? ST_SAT : ST_OK;
		end
	end

	assign done        = v_s11;
	assign y_corrected = y_s11;
	assign e_corrected = e_s11;
	assign status      = st_s11;

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result beat without a matching point");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_DZ |->
			(y_corrected == WORD_MAX || y_corrected == WORD_MIN) &&
			(e_corrected == WORD_MAX || e_corrected == WORD_MIN))
		else $error("zero factor beat not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ex_s4.q <= Q_LIMIT)
		else $error("ln2 split quotient out of range");

endmodule

// ===== hdl/omx_split_cell.sv =====
module omx_split_cell import omx_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  ex_t  ex_in,
	output logic v_s1,
	output ex_t  ex_s1
);

	localparam logic [SPLIT_W-1:0] STEP = LN2_Q << SHIFT;

	logic ge;
	ex_t  ex_nx;

	assign ge = ex_in.mag >= STEP;

	always_comb begin
		ex_nx     = ex_in;
		ex_nx.mag = ge ? ex_in.mag - STEP : ex_in.mag;
		ex_nx.q   = {ex_in.q[Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= ex_nx;
	end

endmodule

// ===== hdl/omx_taylor_cell.sv =====
module omx_taylor_cell import omx_pkg::*; #(
	parameter int N = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  ex_t  ex_in,
	output logic v_s3,
	output ex_t  ex_s3
);

	localparam logic [32:0] RECIP = 33'((65'd1 << 32) / N);
	localparam logic [35:0] DIVN  = 36'(N);

	logic        v_s1, v_s2;
	ex_t         ex_s1, ex_s2, ex_nx;
	logic [31:0] t_s1, t_s2, q_s2;
	logic [64:0] prod, qm;
	logic [35:0] rem;
	logic [31:0] nt;

	assign prod = 65'(ex_in.term) * 65'(ex_in.r);
	assign qm   = 65'(t_s1) * 65'(RECIP);
	assign rem  = 36'(t_s2) - 36'(q_s2) * DIVN;
	assign nt   = q_s2 + 32'(rem >= DIVN);

	always_comb begin
		ex_nx      = ex_s2;
		ex_nx.term = 33'(nt);
		ex_nx.sum  = ex_s2.sum + 34'(nt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= ex_in;
		t_s1  <= prod[63:32];
		ex_s2 <= ex_s1;
		t_s2  <= t_s1;
		q_s2  <= qm[63:32];
		ex_s3 <= ex_nx;
	end

endmodule

// ===== hdl/omx_div_cell.sv =====
module omx_div_cell import omx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  ln_t  ln_in,
	output logic v_s1,
	output ln_t  ln_s1
);

	logic [MAG_W:0] rem2, dvs, diff;
	logic           ge;
	ln_t            ln_nx;

	assign rem2 = {ln_in.rem, ln_in.low[31]};
	assign dvs  = {1'b0, ln_in.fmag};
	assign ge   = rem2 >= dvs;
	assign diff = rem2 - dvs;

	always_comb begin
		ln_nx     = ln_in;
		ln_nx.rem = ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
		ln_nx.low = {ln_in.low[30:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		ln_s1 <= ln_nx;
	end

endmodule

// ===== hdl/omx_lane.sv =====
module omx_lane import omx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_in,
	input  logic [WORD_BITS-1:0] raw,
	input  logic [MAG_W-1:0]     fmag,
	input  logic                 fneg,
	input  logic                 dm,
	input  tag_t                 tag_in,
	output logic                 v_s5,
	output logic [WORD_BITS-1:0] word_s5,
	output logic                 sat_s5,
	output logic                 vneg_s5,
	output tag_t                 tag_s5
);

	logic        v_s1, v_s2, v_s3, v_s4;
	ln_t         ln_s1, ln_s2, ln_s3, ln_s4, ln_cur;
	logic        vneg;
	logic [31:0] vm;
	logic [63:0] num;
	logic [63:0] plo_s2, plo_s3;
	logic [62:0] phi_s3;
	logic [PROD_W-1:0] tot_s4;
	logic [63:0] mq, lim, m;
	logic        sat;

	logic dv   [0:DIV_CELLS];
	ln_t  dln  [0:DIV_CELLS];

	assign vneg = raw[WORD_BITS-1];
	assign vm   = vneg ? 32'(-raw) : raw;
	assign num  = {vm, 32'd0} + 64'(fmag >> 1);

	always_comb begin
		ln_cur      = '0;
		ln_cur.vm   = vm;
		ln_cur.fmag = fmag;
		ln_cur.vneg = vneg;
		ln_cur.rneg = vneg ^ fneg;
		ln_cur.ovf  = 63'(num[63:32]) >= fmag;
		ln_cur.rem  = 63'(num[63:32]);
		ln_cur.low  = num[31:0];
		ln_cur.tag  = tag_in;
	end

	assign dv[0]  = v_s1;
	assign dln[0] = ln_s1;

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		omx_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (dv[i]),
			.ln_in  (dln[i]),
			.v_s1   (dv[i+1]),
			.ln_s1  (dln[i+1])
		);
	end

	assign mq  = tot_s4[PROD_W-1:IFRAC];
	assign lim = ln_s4.rneg ? 64'(WORD_MIN) : 64'(WORD_MAX);

	always_comb begin
		m   = '0;
		sat = 1'b0;
		if (dm) begin
			if (ln_s4.ovf || 64'(ln_s4.low) > lim) begin
				m   = lim;
				sat = 1'b1;
			end else begin
				m = 64'(ln_s4.low);
			end
		end else begin
			if (mq > lim) begin
				m   = lim;
				sat = 1'b1;
			end else begin
				m = mq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= dv[DIV_CELLS];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ln_s1   <= ln_cur;
		ln_s2   <= dln[DIV_CELLS];
		plo_s2  <= 64'(dln[DIV_CELLS].vm) * 64'(dln[DIV_CELLS].fmag[31:0]);
		ln_s3   <= ln_s2;
		plo_s3  <= plo_s2;
		phi_s3  <= 63'(ln_s2.vm) * 63'(ln_s2.fmag[62:32]);
		ln_s4   <= ln_s3;
		tot_s4  <= PROD_W'(plo_s3) + (PROD_W'(phi_s3) << 32) + (PROD_W'(1) << (IFRAC-1));
		word_s5 <= (ln_s4.rneg && m != 64'd0) ? WORD_BITS'(-m) : m[WORD_BITS-1:0];
		sat_s5  <= sat;
		vneg_s5 <= ln_s4.vneg;
		tag_s5  <= ln_s4.tag;
	end

endmodule
